[rtl/pec_pkg.sv]
// Shared types, character constants and hex helpers for the percent escape codec.
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int MAX_RESULTS = 3;

    // Register indexes (byte address = 8 * index).
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_MASK0 = 3'd1;
    localparam logic [2:0] REG_MASK1 = 3'd2;
    localparam logic [2:0] REG_MASK2 = 3'd3;
    localparam logic [2:0] REG_MASK3 = 3'd4;

    // Characters used by the escape forms.
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
    localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
    localparam logic [7:0] CH_LOW_F = 8'h66;  // 'f'

    typedef enum logic [1:0] {
        MODE_PATH   = 2'd0,
        MODE_CUSTOM = 2'd1,
        MODE_PRINT  = 2'd2,
        MODE_DECODE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Settings seen by the front end.
    typedef struct packed {
        t_mode        mode;
        logic [255:0] mask;
    } t_cfg;

    // One classified item: 1 to 3 bytes, emitted from index 0 upward.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        last;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic logic [7:0] hex_upper(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h37 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = c[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/pec_front.sv]
// Front end: accepts input bytes, tracks the decode escape and turns bytes into queued jobs.
`timescale 1ns / 1ps
`default_nettype none

module pec_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pec_pkg::t_cfg     i_cfg,
    input  wire logic              i_in_valid,
    input  wire pec_pkg::t_in_item i_in_data,
    input  wire logic              i_full,
    output logic                   o_accept,
    output logic                   o_push,
    output pec_pkg::t_job          o_job
);
    import pec_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic [7:0] b;
    logic       lst;
    t_hex       hi, lo;
    logic [7:0] dec_val;

    assign b        = i_in_data.in_byte;
    assign lst      = i_in_data.in_last;
    assign o_accept = i_in_valid && !i_full;
    assign hi       = hex_decode(r_held);
    assign lo       = hex_decode(b);

    always_comb begin
        if (!hi.ok) begin
            dec_val = 8'd0;
        end else if (!lo.ok) begin
            dec_val = {4'd0, hi.val};
        end else begin
            dec_val = {hi.val, lo.val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        o_push  = 1'b0;
        o_job   = '0;
        o_job.last     = lst;
        o_job.count    = 2'd1;
        o_job.bytes[0] = b;
        if (o_accept) begin
            if (i_cfg.mode != MODE_DECODE) begin
                // Encode modes drop any pending escape.
                n_phase = PH_IDLE;
                n_held  = 8'd0;
                o_push  = 1'b1;
            end
            unique case (i_cfg.mode)
                MODE_PATH: begin
                    if (b == CH_SLASH || b == CH_PCT) begin
                        o_job.count    = 2'd3;
                        o_job.bytes[0] = CH_PCT;
                        o_job.bytes[1] = CH_TWO;
                        o_job.bytes[2] = (b == CH_SLASH) ? CH_LOW_F : CH_FIVE;
                    end
                end
                MODE_CUSTOM: begin
                    if (i_cfg.mask[b]) begin
                        o_job.count    = 2'd3;
                        o_job.bytes[0] = CH_PCT;
                        o_job.bytes[1] = hex_upper(b[7:4]);
                        o_job.bytes[2] = hex_upper(b[3:0]);
                    end
                end
                MODE_PRINT: begin
                    if (b == CH_PCT) begin
                        o_job.count    = 2'd2;
                        o_job.bytes[1] = CH_PCT;
                    end
                end
                MODE_DECODE: begin
                    unique case (r_phase)
                        PH_PCT: begin
                            if (lst) begin
                                // Too few characters left: pass '%' through literally.
                                o_push         = 1'b1;
                                o_job.count    = 2'd2;
                                o_job.bytes[0] = CH_PCT;
                                o_job.bytes[1] = b;
                                n_phase        = PH_IDLE;
                            end else begin
                                n_held  = b;
                                n_phase = PH_DIGIT;
                            end
                        end
                        PH_DIGIT: begin
                            o_push         = 1'b1;
                            o_job.bytes[0] = dec_val;
                            n_phase        = PH_IDLE;
                            n_held         = 8'd0;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            if (b == CH_PCT && !lst) begin
                                n_phase = PH_PCT;
                            end else begin
                                o_push = 1'b1;
                            end
                        end
                    endcase
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/pec_fifo.sv]
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pec_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pec_pkg::t_job i_wdata,
    input  wire logic          i_pop,
    output pec_pkg::t_job      o_rdata,
    output logic               o_full,
    output logic               o_empty
);
    import pec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

[rtl/pec_back.sv]
// Back end: walks the head job one byte per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module pec_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pec_pkg::t_job      i_head,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pec_pkg::t_out_item      o_out_data
);
    import pec_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_out_item  r_out, n_out;
    logic       load;
    logic       final_byte;

    assign load        = !r_valid || !i_out_stall;
    assign final_byte  = (r_idx == 2'(i_head.count - 2'd1));
    assign o_pop       = load && !i_empty && final_byte;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_out   = r_out;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_out.out_byte = i_head.bytes[r_idx];
                n_out.out_last = i_head.last && final_byte;
                // Advance within the job, or rewind once its last byte leaves.
                n_idx = final_byte ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> (!i_empty && (r_idx < i_head.count)))
        else $error("byte index outside the head job");
`endif

endmodule

`default_nettype wire

[rtl/percent_escape_codec.sv]
// An accepted byte's job is queued; the output register then loads its first byte.
// Throughput: one input byte per cycle while each makes one output byte and the output
//   is not stalled; the output register moves one byte per cycle while not stalled.
// A held '%' or digit in decode mode is consumed and makes no output.
// Reset (synchronous, active low) clears mode, masks, escape state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module percent_escape_codec #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire pec_pkg::t_in_item            i_in_data,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output pec_pkg::t_out_item                o_out_data,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pec_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pec_pkg::DATA_W-1:0]   pwdata,
    output logic [pec_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import pec_pkg::*;

    // Configuration registers.
    t_mode       r_mode;
    logic [63:0] r_mask0, r_mask1, r_mask2, r_mask3;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    t_cfg        cfg;

    // Front to queue to back.
    logic        accept;
    logic        push;
    t_job        push_job;
    t_job        head_job;
    logic        q_full;
    logic        q_empty;
    logic        pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    // Register writes; addresses past the last register drop the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PATH;
            r_mask0 <= '0;
            r_mask1 <= '0;
            r_mask2 <= '0;
            r_mask3 <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MODE:  r_mode  <= t_mode'(pwdata[1:0]);
                REG_MASK0: r_mask0 <= pwdata;
                REG_MASK1: r_mask1 <= pwdata;
                REG_MASK2: r_mask2 <= pwdata;
                REG_MASK3: r_mask3 <= pwdata;
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:  prdata = {{(DATA_W-2){1'b0}}, r_mode};
            REG_MASK0: prdata = r_mask0;
            REG_MASK1: prdata = r_mask1;
            REG_MASK2: prdata = r_mask2;
            REG_MASK3: prdata = r_mask3;
            default:   prdata = '0;
        endcase
    end

    // Mask bit b of the flat vector escapes byte value b.
    assign cfg.mode = r_mode;
    assign cfg.mask = {r_mask3, r_mask2, r_mask1, r_mask0};

    // Hold the input off only while the job queue is full.
    assign o_in_stall = q_full;

    pec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_accept   (accept),
        .o_push     (push),
        .o_job      (push_job)
    );

    pec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_job),
        .i_pop   (pop),
        .o_rdata (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (accept && !q_full))
        else $error("job queued without an input transfer");
`endif

endmodule

`default_nettype wire
